/* sv/pdsr_pkg.sv */
// shared types, register indexes and the slew step function for the pwm duty ramp
package pdsr_pkg;

    localparam int DUTY_W = 16;
    localparam int CHAN_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY      = 2'd3;

    // input modes and result kinds
    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // one channel entry of the state memory
    typedef struct packed {
        logic [DUTY_W-1:0] target;
        logic [DUTY_W-1:0] duty;
        logic [DUTY_W-1:0] countdown;
    } t_chan;

    // one limited step of the duty toward the goal
    function automatic logic [DUTY_W-1:0] slew_step(
        input logic [DUTY_W-1:0] goal,
        input logic [DUTY_W-1:0] now,
        input logic [DUTY_W-1:0] step
    );
        logic [DUTY_W-1:0] res;
        if (goal >= now) begin
            res = ((goal - now) >= step) ? (now + step) : goal;
        end else begin
            res = ((now - goal) >= step) ? (now - step) : goal;
        end
        return res;
    endfunction

endpackage

/* sv/pdsr_in_if.sv */
// input channel: mode, channel and value with valid/ready
interface pdsr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [pdsr_pkg::CHAN_W-1:0]   channel;
    logic [pdsr_pkg::DUTY_W-1:0]   value;

    modport source (output valid, output mode, output channel, output value, input ready);
    modport sink   (input valid, input mode, input channel, input value, output ready);
endinterface

/* sv/pdsr_out_if.sv */
// output channel: one ramp result with valid/ready
interface pdsr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic                          accepted;
    logic [pdsr_pkg::CHAN_W-1:0]   out_channel;
    logic [pdsr_pkg::DUTY_W-1:0]   duty;
    logic                          at_target;
    logic                          last;

    modport source (output valid, output kind, output accepted, output out_channel,
                    output duty, output at_target, output last, input ready);
    modport sink   (input valid, input kind, input accepted, input out_channel,
                    input duty, input at_target, input last, output ready);
endinterface

/* sv/pdsr_chan_mem.sv */
// per-channel state memory with registered read and reset-valid bits
module pdsr_chan_mem #(
    parameter int DEPTH     = 2,
    parameter int INIT_DUTY = 0,
    parameter int AW        = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [AW-1:0]         i_rd_addr,
    output pdsr_pkg::t_chan       o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  pdsr_pkg::t_chan       i_wr_data
);

    pdsr_pkg::t_chan r_mem [DEPTH];
    pdsr_pkg::t_chan r_rd;
    logic [DEPTH-1:0] r_vld;
    logic             r_rvld;
    pdsr_pkg::t_chan  w_init;

    always_comb begin
        w_init.target    = '0;
        w_init.duty      = pdsr_pkg::DUTY_W'(INIT_DUTY);
        w_init.countdown = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // entries not yet written read as their reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rvld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rvld ? r_rd : w_init;

endmodule

/* sv/pwm_duty_slew_ramp_core.sv */
// pwm duty ramp with slew limiting over several channels, state held in one memory
// a set result passes the read, modify and flush states before the output register;
// a rejected set goes straight to flush; input is ready only in idle, so a new item
// is taken only once the last is flushed; a tick does a memory read-modify-write per channel
// reset: synchronous active low; control and config registers reset, every channel
// reads as target 0, duty INIT_DUTY, countdown 0 straight away (no clearing pass)
module pwm_duty_slew_ramp_core #(
    parameter int CHANNELS  = 2,
    parameter int INIT_DUTY = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pdsr_in_if.sink                           i_in,
    pdsr_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [pdsr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdsr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW    = pdsr_pkg::DUTY_W;
    localparam int CW    = pdsr_pkg::CHAN_W;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_MOD   = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [DW-1:0] r_step_size, r_step_interval, r_min_duty, r_max_duty;

    // latched item
    logic          r_mode, n_mode;
    logic [DW-1:0] r_val, n_val;
    logic [IDX_W-1:0] r_idx, n_idx;

    // pending result: held until we know whether a later channel also steps
    logic          r_pv, n_pv;
    logic          r_pkind, n_pkind;
    logic          r_pacc, n_pacc;
    logic [CW-1:0] r_pch, n_pch;
    logic [DW-1:0] r_pduty, n_pduty;
    logic          r_pat, n_pat;

    // output register
    logic          r_ov;
    logic          r_okind, r_oacc, r_oat, r_olast;
    logic [CW-1:0] r_och;
    logic [DW-1:0] r_oduty;

    logic          w_push, w_push_last, w_can_push;

    // memory port signals
    pdsr_pkg::t_chan w_rd, w_wr;
    logic            w_wr_en;

    // step computation
    logic [DW-1:0] w_set_duty, w_tick_duty, w_cd_dec;
    logic          w_fire, w_tick_at, w_bad_set;
    logic [CW-1:0] w_cur_ch;

    pdsr_chan_mem #(
        .DEPTH     (CHANNELS),
        .INIT_DUTY (INIT_DUTY),
        .AW        (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr)
    );

    // configuration writes, the two-bit index selects one of the four registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size     <= DW'(10);
            r_step_interval <= DW'(10);
            r_min_duty      <= '0;
            r_max_duty      <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdsr_pkg::CFG_STEP_SIZE:     r_step_size     <= i_cfg_data;
                pdsr_pkg::CFG_STEP_INTERVAL: r_step_interval <= i_cfg_data;
                pdsr_pkg::CFG_MIN_DUTY:      r_min_duty      <= i_cfg_data;
                pdsr_pkg::CFG_MAX_DUTY:      r_max_duty      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_can_push = !r_ov || o_out.ready;

    // set validity: channel counted from 1, value inside the limits
    assign w_bad_set = (i_in.channel == '0) || (i_in.channel > CW'(CHANNELS))
                     || (i_in.value > r_max_duty) || (i_in.value < r_min_duty);

    assign w_cur_ch    = CW'(r_idx) + CW'(1);
    assign w_set_duty  = pdsr_pkg::slew_step(r_val, w_rd.duty, r_step_size);
    assign w_tick_duty = pdsr_pkg::slew_step(w_rd.target, w_rd.duty, r_step_size);
    assign w_tick_at   = (w_tick_duty == w_rd.target);
    assign w_cd_dec    = w_rd.countdown - DW'(1);
    // countdown of one reaches zero on this tick
    assign w_fire      = (w_rd.countdown == DW'(1));

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_val       = r_val;
        n_idx       = r_idx;
        n_pv        = r_pv;
        n_pkind     = r_pkind;
        n_pacc      = r_pacc;
        n_pch       = r_pch;
        n_pduty     = r_pduty;
        n_pat       = r_pat;
        w_push      = 1'b0;
        w_push_last = 1'b0;
        w_wr_en     = 1'b0;
        w_wr        = w_rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_mode = i_in.mode;
                    n_val  = i_in.value;
                    if (i_in.mode == pdsr_pkg::MODE_TICK) begin
                        n_idx   = '0;
                        n_state = S_READ;
                    end else if (w_bad_set) begin
                        // rejected set: a single result, no state touched
                        n_pv    = 1'b1;
                        n_pkind = pdsr_pkg::KIND_SET;
                        n_pacc  = 1'b0;
                        n_pch   = i_in.channel;
                        n_pduty = '0;
                        n_pat   = 1'b0;
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = IDX_W'(i_in.channel - CW'(1));
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                // memory read at r_idx lands next cycle
                n_state = S_MOD;
            end
            S_MOD: begin
                if (r_mode == pdsr_pkg::MODE_SET) begin
                    w_wr_en          = 1'b1;
                    w_wr.target      = r_val;
                    w_wr.duty        = w_set_duty;
                    w_wr.countdown   = r_step_interval;
                    n_pv    = 1'b1;
                    n_pkind = pdsr_pkg::KIND_SET;
                    n_pacc  = 1'b1;
                    n_pch   = w_cur_ch;
                    n_pduty = w_set_duty;
                    n_pat   = (w_set_duty == r_val);
                    n_state = S_FLUSH;
                end else if (!(w_fire && r_pv && !w_can_push)) begin
                    // tick: hold here while an earlier step cannot be sent on
                    w_wr_en = (w_rd.countdown != '0);
                    if (w_fire) begin
                        w_wr.duty      = w_tick_duty;
                        w_wr.countdown = w_tick_at ? '0 : r_step_interval;
                        w_push         = r_pv;
                        n_pv    = 1'b1;
                        n_pkind = pdsr_pkg::KIND_STEP;
                        n_pacc  = 1'b1;
                        n_pch   = w_cur_ch;
                        n_pduty = w_tick_duty;
                        n_pat   = w_tick_at;
                    end else begin
                        w_wr.countdown = w_cd_dec;
                    end
                    if (r_idx == IDX_W'(CHANNELS - 1)) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_FLUSH: begin
                // the held result is the final one of this item
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (w_can_push) begin
                    w_push      = 1'b1;
                    w_push_last = 1'b1;
                    n_pv        = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_pkind <= n_pkind;
        r_pacc  <= n_pacc;
        r_pch   <= n_pch;
        r_pduty <= n_pduty;
        r_pat   <= n_pat;
        if (w_push) begin
            r_okind <= r_pkind;
            r_oacc  <= r_pacc;
            r_och   <= r_pch;
            r_oduty <= r_pduty;
            r_oat   <= r_pat;
            r_olast <= w_push_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_okind;
    assign o_out.accepted    = r_oacc;
    assign o_out.out_channel = r_och;
    assign o_out.duty        = r_oduty;
    assign o_out.at_target   = r_oat;
    assign o_out.last        = r_olast;

endmodule
